### src/uart_rx_tx_ring_buffers_top_macros.svh
// Assertion helpers shared by the ring buffer modules.
`ifndef UART_RX_TX_RING_BUFFERS_TOP_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define URTRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define URTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/urtrb_pkg.sv
`timescale 1ns / 1ps
package urtrb_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int LEVEL_W        = 9;
    localparam int CMDQ_DEPTH     = 2;

    localparam logic [1:0] OP_LINE_RX    = 2'd0;
    localparam logic [1:0] OP_HOST_READ  = 2'd1;
    localparam logic [1:0] OP_HOST_WRITE = 2'd2;
    localparam logic [1:0] OP_TX_READY   = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic               read_valid;
        logic [7:0]         read_byte;
        logic               line_end;
        logic               send_valid;
        logic [7:0]         send_byte;
        logic               overflow;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } t_out_item;

    // Decoded command handed from the front queue to the ring engine.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       is_lf;
    } t_cmd;

endpackage

### src/urtrb_front.sv
`timescale 1ns / 1ps
`include "uart_rx_tx_ring_buffers_top_macros.svh"
module urtrb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  urtrb_pkg::t_in_item i_in_item,
    output logic              o_full,
    output logic              o_cmd_valid,
    output urtrb_pkg::t_cmd   o_cmd,
    input  logic              i_cmd_take
);
    import urtrb_pkg::*;

    localparam int QIDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_q [CMDQ_DEPTH];
    logic [QIDX_W-1:0] r_wr_idx;
    logic [QIDX_W-1:0] r_rd_idx;
    logic [QCNT_W-1:0] r_cnt;
    logic              push_ok;
    t_cmd              new_cmd;

    function automatic logic [QIDX_W-1:0] f_next(input logic [QIDX_W-1:0] p);
        return (p == QIDX_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full      = (r_cnt == QCNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_idx];
    assign push_ok     = i_push && !o_full;

    // Classify at entry: flag a line feed so the back end knows to queue CR first.
    always_comb begin
        new_cmd.op    = i_in_item.opcode;
        new_cmd.data  = i_in_item.data_in;
        new_cmd.is_lf = (i_in_item.data_in == CH_LF);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_idx] <= new_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_cnt    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_idx <= f_next(r_wr_idx);
            end
            if (i_cmd_take) begin
                r_rd_idx <= f_next(r_rd_idx);
            end
            case ({push_ok, i_cmd_take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `URTRB_ASSERT_NOW(a_take_nonempty, i_clk, i_rst_n, i_cmd_take, r_cnt != '0, "take from empty queue")
    `URTRB_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, push_ok && !i_cmd_take, r_cnt != '0, "push lost")
    `URTRB_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_W'(CMDQ_DEPTH), "queue overfilled")

endmodule

### src/urtrb_back.sv
`timescale 1ns / 1ps
`include "uart_rx_tx_ring_buffers_top_macros.svh"
module urtrb_back #(
    parameter int RING_DEPTH = urtrb_pkg::RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  urtrb_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_take,
    input  logic                 i_pop,
    output logic                 o_empty,
    output urtrb_pkg::t_out_item o_out_item
);
    import urtrb_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RX_READ = 2'd1;
    localparam logic [1:0] ST_TX_READ = 2'd2;
    localparam logic [1:0] ST_TX_LF   = 2'd3;

    logic [7:0]       rx_mem [RING_DEPTH];
    logic [7:0]       tx_mem [RING_DEPTH];

    logic [1:0]       r_state, n_state;
    logic [PTR_W-1:0] r_rx_rptr, n_rx_rptr, r_rx_wptr, n_rx_wptr;
    logic [PTR_W-1:0] r_tx_rptr, n_tx_rptr, r_tx_wptr, n_tx_wptr;
    logic [CNT_W-1:0] r_rx_cnt, n_rx_cnt, r_tx_cnt, n_tx_cnt;
    logic [7:0]       r_rx_rdata, r_tx_rdata;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             slot_free, start, load;
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [7:0]       tx_wdata;
    t_out_item        res;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign slot_free  = !r_out_valid || i_pop;
    assign start      = (r_state == ST_IDLE) && i_cmd_valid && slot_free;
    assign o_cmd_take = start;
    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;

    always_comb begin
        n_state   = r_state;
        n_rx_rptr = r_rx_rptr;
        n_rx_wptr = r_rx_wptr;
        n_rx_cnt  = r_rx_cnt;
        n_tx_rptr = r_tx_rptr;
        n_tx_wptr = r_tx_wptr;
        n_tx_cnt  = r_tx_cnt;
        rx_we     = 1'b0;
        rx_re     = 1'b0;
        tx_we     = 1'b0;
        tx_re     = 1'b0;
        tx_wdata  = i_cmd.data;
        load      = 1'b0;
        res       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        OP_LINE_RX: begin
                            load = 1'b1;
                            if (r_rx_cnt != CNT_W'(RING_DEPTH)) begin
                                rx_we     = 1'b1;
                                n_rx_wptr = f_next(r_rx_wptr);
                                n_rx_cnt  = r_rx_cnt + 1'b1;
                            end else begin
                                res.overflow = 1'b1;
                            end
                        end
                        OP_HOST_READ: begin
                            if (r_rx_cnt != '0) begin
                                rx_re   = 1'b1;
                                n_state = ST_RX_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_HOST_WRITE: begin
                            if (i_cmd.is_lf) begin
                                if (r_tx_cnt <= CNT_W'(RING_DEPTH - 2)) begin
                                    tx_we     = 1'b1;
                                    tx_wdata  = CH_CR;
                                    n_tx_wptr = f_next(r_tx_wptr);
                                    n_tx_cnt  = r_tx_cnt + 1'b1;
                                    n_state   = ST_TX_LF;
                                end else begin
                                    load         = 1'b1;
                                    res.overflow = 1'b1;
                                end
                            end else begin
                                load = 1'b1;
                                if (r_tx_cnt != CNT_W'(RING_DEPTH)) begin
                                    tx_we     = 1'b1;
                                    n_tx_wptr = f_next(r_tx_wptr);
                                    n_tx_cnt  = r_tx_cnt + 1'b1;
                                end else begin
                                    res.overflow = 1'b1;
                                end
                            end
                        end
                        OP_TX_READY: begin
                            if (r_tx_cnt != '0) begin
                                tx_re   = 1'b1;
                                n_state = ST_TX_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_RX_READ: begin
                load           = 1'b1;
                res.read_valid = 1'b1;
                res.read_byte  = r_rx_rdata;
                res.line_end   = (r_rx_rdata == CH_CR) || (r_rx_rdata == CH_LF);
                n_rx_rptr      = f_next(r_rx_rptr);
                n_rx_cnt       = r_rx_cnt - 1'b1;
                n_state        = ST_IDLE;
            end
            ST_TX_READ: begin
                load           = 1'b1;
                res.send_valid = 1'b1;
                res.send_byte  = r_tx_rdata;
                n_tx_rptr      = f_next(r_tx_rptr);
                n_tx_cnt       = r_tx_cnt - 1'b1;
                n_state        = ST_IDLE;
            end
            ST_TX_LF: begin
                load      = 1'b1;
                tx_we     = 1'b1;
                tx_wdata  = CH_LF;
                n_tx_wptr = f_next(r_tx_wptr);
                n_tx_cnt  = r_tx_cnt + 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        res.rx_level = LEVEL_W'(n_rx_cnt);
        res.tx_level = LEVEL_W'(n_tx_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[r_rx_wptr] <= i_cmd.data;
        end
        if (rx_re) begin
            r_rx_rdata <= rx_mem[r_rx_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_mem[r_tx_wptr] <= tx_wdata;
        end
        if (tx_re) begin
            r_tx_rdata <= tx_mem[r_tx_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_rptr   <= '0;
            r_rx_wptr   <= '0;
            r_rx_cnt    <= '0;
            r_tx_rptr   <= '0;
            r_tx_wptr   <= '0;
            r_tx_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rx_rptr <= n_rx_rptr;
            r_rx_wptr <= n_rx_wptr;
            r_rx_cnt  <= n_rx_cnt;
            r_tx_rptr <= n_tx_rptr;
            r_tx_wptr <= n_tx_wptr;
            r_tx_cnt  <= n_tx_cnt;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `URTRB_ASSERT_NOW(a_rx_bound, i_clk, i_rst_n, 1'b1,
        r_rx_cnt <= CNT_W'(RING_DEPTH), "rx ring over depth")
    `URTRB_ASSERT_NOW(a_tx_bound, i_clk, i_rst_n, 1'b1,
        r_tx_cnt <= CNT_W'(RING_DEPTH), "tx ring over depth")
    `URTRB_ASSERT_NOW(a_take_slot, i_clk, i_rst_n, o_cmd_take,
        !r_out_valid || i_pop, "command taken with result slot busy")
    `URTRB_ASSERT_NEXT(a_lf_done, i_clk, i_rst_n, r_state == ST_TX_LF,
        r_state == ST_IDLE && r_out_valid, "CR LF pair not finished")

endmodule

### src/uart_rx_tx_ring_buffers_top.sv
`timescale 1ns / 1ps
// Buffered UART front end: a receive ring and a transmit ring behind two queue-style ports.
// Input channel: drive i_in_item and raise push; the transfer happens on a clock edge where
//   full is low. Opcodes: line byte received, host read, host write, transmitter ready.
// Result channel: while empty is low, o_out_item holds the oldest result; raise pop to take it.
//   Every item gives exactly one result, in order, carrying both ring levels after the step.
// A two-entry command queue sits in front of the ring engine, so items keep arriving while
//   a finished result waits to be taken.
// A line byte, a plain host write, or a read/tick on an empty ring finishes straight from
//   the idle state; a host read, a transmitter tick and a LF write (CR then LF) pass through
//   a further engine state (ring read or LF write) before its result loads.
// Throughput: one item per cycle for single-step operations while each result is popped; reads,
//   ticks and LF writes make the next item wait (registered ring read, single write per ring).
// Reset (synchronous, active low) clears pointers, counts, the command queue and the result
//   valid flag; ring contents and result data are not cleared and need no clearing pass.
// Receiver stall: the engine holds while a result is not popped; the command queue then
//   fills and full rises, back-pressuring the sender without losing anything.
// A full ring drops the byte and sets overflow; a LF write needs two free slots.
module uart_rx_tx_ring_buffers_top #(
    parameter int RING_DEPTH = urtrb_pkg::RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  urtrb_pkg::t_in_item  i_in_item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output urtrb_pkg::t_out_item o_out_item
);
    import urtrb_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    // Front end: accept, decode and queue commands.
    urtrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_item   (i_in_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Back end: ring memories, pointers, counts and the result register.
    urtrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import urtrb_pkg::*;

    localparam int RING       = RING_DEPTH_DEF;
    // Cycles without any transfer on either port before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 1250;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      push       = 1'b0;
    t_in_item  i_in_item  = '0;
    logic      pop        = 1'b0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    // Commands not yet transferred into the block, oldest first.
    t_in_item  cmds_waiting[$];
    // Results the rings must still produce, oldest first.
    t_out_item results_due[$];

    // Shadow copy of both rings.
    logic [7:0]  rx_mem[RING];
    logic [7:0]  tx_mem[RING];
    int unsigned rx_rd, rx_wr, rx_count;
    int unsigned tx_rd, tx_wr, tx_count;

    // Idle chances in percent, changed per phase by the sequencer.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          n_errors      = 0;
    int          n_queued      = 0;
    int          quiet_cycles  = 0;
    t_out_item   seen;
    t_out_item   want;

    uart_rx_tx_ring_buffers_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (i_in_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ring prediction
    // ------------------------------------------------------------------
    function automatic void tx_put(logic [7:0] b);
        tx_mem[tx_wr] = b;
        tx_wr         = (tx_wr + 1) % RING;
        tx_count++;
    endfunction

    // Apply one command to the shadow rings and return the result it must give.
    function automatic t_out_item ring_step(t_in_item cmd);
        t_out_item   r;
        int unsigned need;
        r = '0;
        case (cmd.opcode)
            OP_LINE_RX: begin
                // Drop the byte on a full receive ring.
                if (rx_count < RING) begin
                    rx_mem[rx_wr] = cmd.data_in;
                    rx_wr         = (rx_wr + 1) % RING;
                    rx_count++;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            OP_HOST_READ: begin
                // An empty ring returns nothing and leaves the state alone.
                if (rx_count > 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_mem[rx_rd];
                    r.line_end   = (rx_mem[rx_rd] == CH_CR) || (rx_mem[rx_rd] == CH_LF);
                    rx_rd        = (rx_rd + 1) % RING;
                    rx_count--;
                end
            end
            OP_HOST_WRITE: begin
                // LF expands to CR LF and needs both slots, never half of the pair.
                need = (cmd.data_in == CH_LF) ? 2 : 1;
                if (RING - tx_count >= need) begin
                    if (cmd.data_in == CH_LF) begin
                        tx_put(CH_CR);
                    end
                    tx_put(cmd.data_in);
                end else begin
                    r.overflow = 1'b1;
                end
            end
            default: begin
                if (tx_count > 0) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = tx_mem[tx_rd];
                    tx_rd        = (tx_rd + 1) % RING;
                    tx_count--;
                end
            end
        endcase
        r.rx_level = rx_count[LEVEL_W-1:0];
        r.tx_level = tx_count[LEVEL_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [8:0] exp_v, logic [8:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Command side: present the oldest waiting command, predict on transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Predict from what was actually on the port at the transfer.
            if (push && !full) begin
                results_due.push_back(ring_step(i_in_item));
                void'(cmds_waiting.pop_front());
            end
            // Hold push high across back-to-back transfers; drop it only to idle.
            if (cmds_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                push      <= 1'b1;
                i_in_item <= cmds_waiting[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: compare each transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                seen = o_out_item;
                if (results_due.size() == 0) begin
                    $error("result transfer with no result due: %h", seen);
                    n_errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("read_valid", want.read_valid, seen.read_valid);
                    check_field("read_byte",  want.read_byte,  seen.read_byte);
                    check_field("line_end",   want.line_end,   seen.line_end);
                    check_field("send_valid", want.send_valid, seen.send_valid);
                    check_field("send_byte",  want.send_byte,  seen.send_byte);
                    check_field("overflow",   want.overflow,   seen.overflow);
                    check_field("rx_level",   want.rx_level,   seen.rx_level);
                    check_field("tx_level",   want.tx_level,   seen.tx_level);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transfer on either port resets the count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic add_cmd(logic [1:0] op, logic [7:0] data);
        t_in_item c;
        c.opcode  = op;
        c.data_in = data;
        cmds_waiting.push_back(c);
        n_queued++;
    endtask

    // Queue a burst biased toward one operation; lf_pct steers bytes toward CR and LF.
    task automatic add_burst(logic [1:0] lead_op, int unsigned lead_pct, int n,
                             int unsigned lf_pct);
        logic [1:0] op;
        logic [7:0] data;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(99) < lead_pct) ? lead_op : 2'($urandom_range(3));
            if ($urandom_range(99) < lf_pct) begin
                data = ($urandom_range(3) == 0) ? CH_CR : CH_LF;
            end else begin
                data = 8'($urandom_range(255));
            end
            add_cmd(op, data);
        end
    endtask

    // Hold the sequencer until every command is in and every result is out.
    task automatic wait_drained();
        while (cmds_waiting.size() != 0 || results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        rx_rd = 0; rx_wr = 0; rx_count = 0;
        tx_rd = 0; tx_wr = 0; tx_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles now and then, receiver mostly stalls.
        send_idle_pct = 32;
        recv_idle_pct = 88;

        // Reads and ticks on empty rings, with all data bits set to show they are ignored.
        add_cmd(OP_HOST_READ, 8'hFF);
        add_cmd(OP_TX_READY,  8'hFF);
        // Line bytes at the extremes and both line-end characters.
        add_cmd(OP_LINE_RX, 8'h00);
        add_cmd(OP_LINE_RX, 8'hFF);
        add_cmd(OP_LINE_RX, CH_CR);
        add_cmd(OP_LINE_RX, CH_LF);
        add_cmd(OP_LINE_RX, 8'h5A);
        // LF write expands to CR LF; CR alone does not.
        add_cmd(OP_HOST_WRITE, CH_LF);
        add_cmd(OP_HOST_WRITE, CH_CR);
        add_cmd(OP_HOST_WRITE, 8'h00);
        add_cmd(OP_HOST_WRITE, 8'hFF);
        // Drain both rings one past empty.
        repeat (6) add_cmd(OP_HOST_READ, 8'h00);
        repeat (6) add_cmd(OP_TX_READY, 8'h00);

        // Flood the receive ring past full, then mix with host writes.
        add_burst(OP_LINE_RX, 100, 270, 10);
        add_burst(OP_HOST_WRITE, 50, 100, 20);
        // Pause the sender until every result is back.
        wait_drained();

        // Phase two: roles of the idle chances swap.
        send_idle_pct = 88;
        recv_idle_pct = 32;
        // LF-heavy writes push the transmit ring against the two-slot edge.
        add_burst(OP_HOST_WRITE, 100, 140, 60);
        add_burst(OP_HOST_READ, 90, 280, 20);
        wait_drained();

        // Phase three: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_burst(OP_TX_READY, 95, 280, 15);
        while (n_queued < ITEM_TARGET) begin
            add_burst(2'($urandom_range(3)), $urandom_range(90, 30), $urandom_range(80, 20), 15);
        end
        wait_drained();

        // Let any late result surface before the verdict.
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/urtrb_pkg.sv
src/urtrb_front.sv
src/urtrb_back.sv
src/uart_rx_tx_ring_buffers_top.sv
tb/tb_top.sv
